FILE: src/srfr_pkg.sv
// ----------------------------------------------------------------------------
// srfr_pkg: shared types and constants of the sensor reply frame receiver
// Frame layout, status codes, register indexes and the result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package srfr_pkg;

    // Frame layout
    localparam int unsigned FRAME_BYTES = 10;
    localparam int unsigned CNT_W       = $clog2(FRAME_BYTES);
    localparam int unsigned SUM_FIRST   = 2;
    localparam int unsigned SUM_LAST    = FRAME_BYTES - 3;
    localparam int unsigned CSUM_IDX    = FRAME_BYTES - 2;
    localparam int unsigned LAST_IDX    = FRAME_BYTES - 1;

    localparam logic [7:0] HEAD_BYTE = 8'hAA;
    localparam logic [7:0] TAIL_BYTE = 8'hAB;

    localparam logic [15:0] TICKS_MAX = 16'hFFFF;

    // Word kinds on the input channel
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_GOOD     = 2'd0;
    localparam logic [1:0] STATUS_BAD_TAIL = 2'd1;
    localparam logic [1:0] STATUS_BAD_SUM  = 2'd2;
    localparam logic [1:0] STATUS_TIMEOUT  = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT_TICKS  = 2'd0,
        CFG_REQUEST_CODE   = 2'd1,
        CFG_QUERY_REQUEST  = 2'd2,
        CFG_QUERY_REPLY    = 2'd3
    } t_cfg_reg;

    // Reset values of the configuration registers
    localparam logic [15:0] TIMEOUT_RESET       = 16'd1000;
    localparam logic [7:0]  REQUEST_RESET       = 8'd4;
    localparam logic [7:0]  QUERY_REQUEST_RESET = 8'd4;
    localparam logic [7:0]  QUERY_REPLY_RESET   = 8'd192;

    // One result word
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  reply_command;
        logic [7:0]  data_zero;
        logic [7:0]  data_one;
        logic [7:0]  data_two;
        logic [7:0]  data_three;
        logic [7:0]  data_four;
        logic [7:0]  data_five;
        logic        request_matched;
        logic [15:0] fine_dust_tenths;
        logic [15:0] coarse_dust_tenths;
    } t_result;

endpackage

`default_nettype wire

FILE: src/sensor_reply_frame_receiver.sv
// ----------------------------------------------------------------------------
// sensor_reply_frame_receiver: particulate sensor reply deframer
// Hunts for the head byte, collects one ten-byte reply, checks tail and
// checksum and reports one result word per frame or per timeout.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------------------------------
//  input    | in        | i_valid / o_stall   | i_kind, i_rx_byte
//  result   | out       | o_valid / i_stall   | o_status .. o_coarse_dust_tenths
//  config   | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
//  Cycles: one input word per clock while o_stall is low. A word is handled
//  in the cycle it is accepted; any result goes into a free result slot.
//  The output register has a one-word skid stage behind it, so input words
//  keep flowing while a result waits; o_stall rises only once both are full.
//  Reset (synchronous, active low) clears the frame state, the tick counter,
//  both result slots and loads the configuration reset values.
//  The frame byte store is not cleared; each byte is written before use.
//
`default_nettype none

module sensor_reply_frame_receiver (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // input words
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_rx_byte,

    // configuration writes
    input  wire logic                          i_cfg_we,
    input  wire logic [srfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [srfr_pkg::CFG_DATA_W-1:0] i_cfg_data,

    // result words
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [7:0]       o_reply_command,
    output logic [7:0]       o_data_zero,
    output logic [7:0]       o_data_one,
    output logic [7:0]       o_data_two,
    output logic [7:0]       o_data_three,
    output logic [7:0]       o_data_four,
    output logic [7:0]       o_data_five,
    output logic             o_request_matched,
    output logic [15:0]      o_fine_dust_tenths,
    output logic [15:0]      o_coarse_dust_tenths
);

    import srfr_pkg::*;

    // configuration
    logic [15:0] r_timeout_ticks;
    logic [7:0]  r_request_code;
    logic [7:0]  r_query_request_code;
    logic [7:0]  r_query_reply_code;

    // frame state
    logic             r_started,    n_started;
    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic [7:0]       r_running_sum, n_running_sum;
    logic [15:0]      r_elapsed,    n_elapsed;
    logic [7:0]       r_frame [FRAME_BYTES];
    logic             store_we;

    // result slots: output register plus skid
    t_result r_out,       n_out;
    logic    r_out_valid, n_out_valid;
    t_result r_skid,      n_skid;
    logic    r_skid_valid, n_skid_valid;

    logic    accept;
    logic    pop;
    logic    push;
    t_result result;

    assign o_stall = r_skid_valid;
    assign accept  = i_valid && !r_skid_valid;
    assign pop     = r_out_valid && !i_stall;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks      <= TIMEOUT_RESET;
            r_request_code       <= REQUEST_RESET;
            r_query_request_code <= QUERY_REQUEST_RESET;
            r_query_reply_code   <= QUERY_REPLY_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_TIMEOUT_TICKS: r_timeout_ticks      <= i_cfg_data;
                CFG_REQUEST_CODE:  r_request_code       <= i_cfg_data[7:0];
                CFG_QUERY_REQUEST: r_query_request_code <= i_cfg_data[7:0];
                CFG_QUERY_REPLY:   r_query_reply_code   <= i_cfg_data[7:0];
                default:           r_timeout_ticks      <= r_timeout_ticks;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // word handling: tick counting, byte collection, frame check
    // ------------------------------------------------------------------
    always_comb begin
        n_started     = r_started;
        n_byte_count  = r_byte_count;
        n_running_sum = r_running_sum;
        n_elapsed     = r_elapsed;
        store_we      = 1'b0;
        push          = 1'b0;
        result        = '0;

        if (accept) begin
            if (i_kind == KIND_TICK) begin
                // saturating tick count; passing the limit ends the frame
                n_elapsed = (r_elapsed == TICKS_MAX) ? r_elapsed : r_elapsed + 16'd1;
                if (n_elapsed > r_timeout_ticks) begin
                    push          = 1'b1;
                    result.status = STATUS_TIMEOUT;
                    n_started     = 1'b0;
                    n_byte_count  = '0;
                    n_running_sum = '0;
                    n_elapsed     = '0;
                end
            end else if (r_started || i_rx_byte == HEAD_BYTE) begin
                n_started = 1'b1;
                store_we  = 1'b1;
                if (r_byte_count >= CNT_W'(SUM_FIRST) && r_byte_count <= CNT_W'(SUM_LAST)) begin
                    n_running_sum = r_running_sum + i_rx_byte;
                end
                if (r_byte_count == CNT_W'(LAST_IDX)) begin
                    // current byte is the tail; bytes 1..8 are in the store
                    push = 1'b1;
                    if (i_rx_byte != TAIL_BYTE) begin
                        result.status = STATUS_BAD_TAIL;
                    end else if (r_running_sum != r_frame[CSUM_IDX]) begin
                        result.status = STATUS_BAD_SUM;
                    end else begin
                        result.status = STATUS_GOOD;
                    end
                    result.reply_command = r_frame[1];
                    result.data_zero     = r_frame[2];
                    result.data_one      = r_frame[3];
                    result.data_two      = r_frame[4];
                    result.data_three    = r_frame[5];
                    result.data_four     = r_frame[6];
                    result.data_five     = r_frame[7];
                    if (r_request_code == r_query_request_code) begin
                        result.request_matched = (r_frame[1] == r_query_reply_code);
                    end else begin
                        result.request_matched = (r_frame[2] == r_request_code);
                    end
                    result.fine_dust_tenths   = {r_frame[3], r_frame[2]};
                    result.coarse_dust_tenths = {r_frame[5], r_frame[4]};
                    n_started     = 1'b0;
                    n_byte_count  = '0;
                    n_running_sum = '0;
                    n_elapsed     = '0;
                end else begin
                    n_byte_count = r_byte_count + CNT_W'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result slots
    // ------------------------------------------------------------------
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;

        if (r_skid_valid) begin
            // no word is accepted while the skid is full
            if (pop) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end
        end else if (pop || !r_out_valid) begin
            n_out       = result;
            n_out_valid = push;
        end else if (push) begin
            n_skid       = result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started     <= 1'b0;
            r_byte_count  <= '0;
            r_running_sum <= '0;
            r_elapsed     <= '0;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            r_started     <= n_started;
            r_byte_count  <= n_byte_count;
            r_running_sum <= n_running_sum;
            r_elapsed     <= n_elapsed;
            r_out_valid   <= n_out_valid;
            r_skid_valid  <= n_skid_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
        if (store_we) begin
            r_frame[r_byte_count] <= i_rx_byte;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_status             = r_out.status;
    assign o_reply_command      = r_out.reply_command;
    assign o_data_zero          = r_out.data_zero;
    assign o_data_one           = r_out.data_one;
    assign o_data_two           = r_out.data_two;
    assign o_data_three         = r_out.data_three;
    assign o_data_four          = r_out.data_four;
    assign o_data_five          = r_out.data_five;
    assign o_request_matched    = r_out.request_matched;
    assign o_fine_dust_tenths   = r_out.fine_dust_tenths;
    assign o_coarse_dust_tenths = r_out.coarse_dust_tenths;

endmodule

`default_nettype wire

FILE: src/srfr_checker.sv
// ----------------------------------------------------------------------------
// srfr_checker: port-level checks for the sensor reply frame receiver
// Watches the result channel and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module srfr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_status,
    input wire logic [7:0]  o_reply_command,
    input wire logic [7:0]  o_data_zero,
    input wire logic [7:0]  o_data_one,
    input wire logic [7:0]  o_data_two,
    input wire logic [7:0]  o_data_three,
    input wire logic [7:0]  o_data_four,
    input wire logic [7:0]  o_data_five,
    input wire logic        o_request_matched,
    input wire logic [15:0] o_fine_dust_tenths,
    input wire logic [15:0] o_coarse_dust_tenths
);

    import srfr_pkg::*;

    // a stalled result word stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)
            && $stable(o_fine_dust_tenths) && $stable(o_coarse_dust_tenths))
        else $error("stalled result word changed");

    // reset empties both result slots
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result slots not empty after reset");

    // dust values are built from the data bytes
    a_dust: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_fine_dust_tenths == {o_data_one, o_data_zero}
            && o_coarse_dust_tenths == {o_data_three, o_data_two})
        else $error("dust value does not match data bytes");

    // a timeout word carries no frame content
    a_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STATUS_TIMEOUT |->
            o_reply_command == 8'd0 && o_data_zero == 8'd0 && o_data_one == 8'd0
            && o_data_two == 8'd0 && o_data_three == 8'd0 && o_data_four == 8'd0
            && o_data_five == 8'd0 && !o_request_matched)
        else $error("timeout word carries frame data");

endmodule

bind sensor_reply_frame_receiver srfr_checker u_srfr_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_stall              (o_stall),
    .o_valid              (o_valid),
    .i_stall              (i_stall),
    .o_status             (o_status),
    .o_reply_command      (o_reply_command),
    .o_data_zero          (o_data_zero),
    .o_data_one           (o_data_one),
    .o_data_two           (o_data_two),
    .o_data_three         (o_data_three),
    .o_data_four          (o_data_four),
    .o_data_five          (o_data_five),
    .o_request_matched    (o_request_matched),
    .o_fine_dust_tenths   (o_fine_dust_tenths),
    .o_coarse_dust_tenths (o_coarse_dust_tenths)
);

`default_nettype wire

FILE: tb/sensor_reply_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// sensor_reply_frame_receiver_tb: self-checking bench for the reply deframer
// Sends byte and tick words through the input channel with random gaps.
// It tracks the head hunt, the frame fill, the checksum and the tick counter
// on its own, and checks every result word field by field against the words
// it expects, while the result side stalls at random.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_reply_frame_receiver_tb;

    import srfr_pkg::*;

    localparam int IDLE_LIMIT = 1000;   // cycles with no handshake or register write before giving up

    // ------------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    logic                  i_kind      = KIND_BYTE;
    logic [7:0]            i_rx_byte   = 8'h00;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_TIMEOUT_TICKS;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    logic [1:0]            o_status;
    logic [7:0]            o_reply_command;
    logic [7:0]            o_data_zero;
    logic [7:0]            o_data_one;
    logic [7:0]            o_data_two;
    logic [7:0]            o_data_three;
    logic [7:0]            o_data_four;
    logic [7:0]            o_data_five;
    logic                  o_request_matched;
    logic [15:0]           o_fine_dust_tenths;
    logic [15:0]           o_coarse_dust_tenths;

    sensor_reply_frame_receiver uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_kind               (i_kind),
        .i_rx_byte            (i_rx_byte),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_status             (o_status),
        .o_reply_command      (o_reply_command),
        .o_data_zero          (o_data_zero),
        .o_data_one           (o_data_one),
        .o_data_two           (o_data_two),
        .o_data_three         (o_data_three),
        .o_data_four          (o_data_four),
        .o_data_five          (o_data_five),
        .o_request_matched    (o_request_matched),
        .o_fine_dust_tenths   (o_fine_dust_tenths),
        .o_coarse_dust_tenths (o_coarse_dust_tenths)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Deframer shadow: configuration and frame state as the bench sees them
    // ------------------------------------------------------------------------
    logic [15:0] cfg_timeout;
    logic [7:0]  cfg_request;
    logic [7:0]  cfg_query_req;
    logic [7:0]  cfg_query_reply;

    logic        hunt_locked;               // head byte seen, frame in progress
    int          frame_fill;                // bytes stored so far, head included
    logic [7:0]  frame_seen [FRAME_BYTES];
    logic [7:0]  data_sum;                  // 8-bit sum over the data bytes
    logic [15:0] tick_age;                  // saturating tick count

    t_result     replies_due [$];           // result words still to arrive
    int          useful_words   = 0;        // words the deframer did not just drop
    int          mismatch_count = 0;
    bit          rush_mode      = 1'b0;     // no sender gaps while set
    int          calm_words     = 0;        // sender words left in a no-gap stretch

    function automatic void rearm_hunt();
        hunt_locked = 1'b0;
        frame_fill  = 0;
        data_sum    = 8'h00;
        tick_age    = 16'h0000;
    endfunction

    // Fold one accepted word into the shadow; queue the result it causes.
    task automatic deframe_word(input logic kind, input logic [7:0] value);
        t_result r;
        r = '0;
        if (kind == KIND_TICK) begin
            useful_words++;
            if (tick_age != TICKS_MAX)
                tick_age++;
            if (tick_age > cfg_timeout) begin
                r.status = STATUS_TIMEOUT;
                replies_due.push_back(r);
                rearm_hunt();
            end
            return;
        end
        if (!hunt_locked) begin
            if (value != HEAD_BYTE)
                return;     // still hunting, byte dropped
            hunt_locked = 1'b1;
            frame_fill  = 0;
            data_sum    = 8'h00;
        end
        useful_words++;
        // a head byte inside a frame is plain data here
        frame_seen[frame_fill] = value;
        if (frame_fill >= SUM_FIRST && frame_fill <= SUM_LAST)
            data_sum = data_sum + value;
        frame_fill++;
        if (frame_fill < FRAME_BYTES)
            return;

        // tail is judged before the checksum
        if (frame_seen[LAST_IDX] != TAIL_BYTE)
            r.status = STATUS_BAD_TAIL;
        else if (data_sum != frame_seen[CSUM_IDX])
            r.status = STATUS_BAD_SUM;
        else
            r.status = STATUS_GOOD;
        r.reply_command = frame_seen[1];
        r.data_zero     = frame_seen[2];
        r.data_one      = frame_seen[3];
        r.data_two      = frame_seen[4];
        r.data_three    = frame_seen[5];
        r.data_four     = frame_seen[6];
        r.data_five     = frame_seen[7];
        // a data query is matched on the reply command, anything else on byte 2
        if (cfg_request == cfg_query_req)
            r.request_matched = (frame_seen[1] == cfg_query_reply);
        else
            r.request_matched = (frame_seen[2] == cfg_request);
        r.fine_dust_tenths   = {frame_seen[3], frame_seen[2]};
        r.coarse_dust_tenths = {frame_seen[5], frame_seen[4]};
        replies_due.push_back(r);
        rearm_hunt();
    endtask

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Mostly back to back, some short gaps, a few long ones, and now and then
    // a stretch of words with no gap at all.
    function automatic int pick_gap();
        int roll;
        if (rush_mode)
            return 0;
        if (calm_words != 0) begin
            calm_words--;
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        if (roll < 96)
            return $urandom_range(30, 8);
        calm_words = $urandom_range(60, 20);
        return 0;
    endfunction

    // Entered and left right after a rising edge. valid stays high past the
    // accepting edge unless the next word has a gap or the bench drains.
    task automatic send_word(input logic kind, input logic [7:0] value);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_kind    <= kind;
        i_rx_byte <= value;
        do @(posedge i_clk); while (o_stall);
        deframe_word(kind, value);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_word(KIND_TICK, 8'($urandom));
    endtask

    // One ten-byte reply. body holds data bytes 0..5, byte 0 in the low bits.
    task automatic send_frame(input logic [7:0] cmd, input logic [47:0] body,
                              input bit sum_ok, input bit tail_ok, input int tick_pct);
        logic [7:0] frame_out [FRAME_BYTES];
        logic [7:0] sum;
        int k;
        sum = 8'h00;
        for (k = 0; k < 6; k++)
            sum = sum + body[8*k +: 8];
        if (!sum_ok)
            sum = sum + 8'($urandom_range(255, 1));
        frame_out[0] = HEAD_BYTE;
        frame_out[1] = cmd;
        for (k = 0; k < 6; k++)
            frame_out[2+k] = body[8*k +: 8];
        frame_out[CSUM_IDX] = sum;
        frame_out[LAST_IDX] = tail_ok ? TAIL_BYTE : TAIL_BYTE ^ 8'($urandom_range(255, 1));
        for (k = 0; k < FRAME_BYTES; k++) begin
            if ($urandom_range(99) < tick_pct)
                send_ticks(1);
            send_word(KIND_BYTE, frame_out[k]);
        end
    endtask

    // Hold the sender until every queued result is back, then let the
    // pipeline settle.
    task automatic drain_replies();
        i_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Writes all four registers; the 8-bit ones get junk in the upper byte.
    task automatic load_settings(input logic [15:0] timeout, input logic [7:0] request,
                                 input logic [7:0] query_req, input logic [7:0] query_reply);
        drain_replies();
        put_reg(CFG_TIMEOUT_TICKS, timeout);
        put_reg(CFG_REQUEST_CODE,  {8'($urandom), request});
        put_reg(CFG_QUERY_REQUEST, {8'($urandom), query_req});
        put_reg(CFG_QUERY_REPLY,   {8'($urandom), query_reply});
        i_cfg_we <= 1'b0;
        cfg_timeout     = timeout;
        cfg_request     = request;
        cfg_query_req   = query_req;
        cfg_query_reply = query_reply;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: check each accepted word, then pick the next stall
    // ------------------------------------------------------------------------
    t_result reply_want;
    int      stall_left = 0;
    int      calm_left  = 0;
    int      stall_roll;

    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (replies_due.size() == 0) begin
                $error("result word with none expected (status %0d)", o_status);
                mismatch_count++;
            end else begin
                reply_want = replies_due.pop_front();
                check_field("status", 16'(reply_want.status), 16'(o_status));
                check_field("reply_command", 16'(reply_want.reply_command),
                            16'(o_reply_command));
                check_field("data_zero", 16'(reply_want.data_zero), 16'(o_data_zero));
                check_field("data_one", 16'(reply_want.data_one), 16'(o_data_one));
                check_field("data_two", 16'(reply_want.data_two), 16'(o_data_two));
                check_field("data_three", 16'(reply_want.data_three), 16'(o_data_three));
                check_field("data_four", 16'(reply_want.data_four), 16'(o_data_four));
                check_field("data_five", 16'(reply_want.data_five), 16'(o_data_five));
                check_field("request_matched", 16'(reply_want.request_matched),
                            16'(o_request_matched));
                check_field("fine_dust_tenths",   reply_want.fine_dust_tenths,
                            o_fine_dust_tenths);
                check_field("coarse_dust_tenths", reply_want.coarse_dust_tenths,
                            o_coarse_dust_tenths);
            end
        end

        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (calm_left != 0) begin
            calm_left <= calm_left - 1;
            i_stall   <= 1'b0;
        end else begin
            stall_roll = $urandom_range(99);
            if (stall_roll < 60) begin
                i_stall <= 1'b0;
            end else if (stall_roll < 88) begin
                i_stall    <= 1'b1;
                stall_left <= $urandom_range(2);
            end else if (stall_roll < 93) begin
                // long stall: fills the output skid and pushes back on the input
                i_stall    <= 1'b1;
                stall_left <= $urandom_range(40, 8);
            end else begin
                i_stall   <= 1'b0;
                calm_left <= $urandom_range(150, 30);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any handshake or register write restarts the count
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset register values; junk before the head is dropped, extremes of data.
    task automatic test_hunt_and_clean_frame();
        send_word(KIND_BYTE, 8'h00);
        send_word(KIND_BYTE, 8'hFF);
        send_word(KIND_BYTE, TAIL_BYTE);
        send_ticks(1);
        send_frame(8'hC0, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 0);
        send_frame(8'h00, 48'h0000_0000_0000, 1'b1, 1'b1, 0);
    endtask

    // Bad checksum with head bytes inside the frame, then bad tail plus bad sum.
    task automatic test_frame_faults();
        send_frame(8'hAA, 48'hAA55_AA01_80AA, 1'b0, 1'b1, 0);
        send_frame(8'hC0, 48'h0102_0304_0506, 1'b0, 1'b0, 0);
    endtask

    // Timeout register at zero and one; a partial frame is dropped on timeout.
    task automatic test_timeout_edges();
        load_settings(16'd0, 8'd4, 8'd4, 8'd192);
        send_ticks(1);
        load_settings(16'd1, 8'd4, 8'd4, 8'd192);
        send_word(KIND_BYTE, HEAD_BYTE);
        send_word(KIND_BYTE, 8'hC0);
        send_ticks(2);
        send_frame(8'hC0, 48'h0000_0012_0034, 1'b1, 1'b1, 0);
    endtask

    // At the top timeout a long run of ticks never fires; a lower timeout
    // afterwards fires on the next tick since the count was kept.
    task automatic test_tick_saturation();
        load_settings(16'hFFFF, 8'd4, 8'd4, 8'd192);
        rush_mode = 1'b1;
        send_ticks(100);
        rush_mode = 1'b0;
        load_settings(16'd5, 8'd4, 8'd4, 8'd192);
        send_ticks(1);
    endtask

    // Both matching rules, with the code registers at their extremes.
    task automatic test_request_matching();
        load_settings(16'd1000, 8'h00, 8'hFF, 8'h00);
        send_frame(8'h00, 48'h0000_0000_1100, 1'b1, 1'b1, 0);
        send_frame(8'h00, 48'h0000_0000_0001, 1'b1, 1'b1, 0);
        load_settings(16'd1000, 8'hFF, 8'hFF, 8'hFF);
        send_frame(8'hFF, 48'h0000_0000_00FF, 1'b1, 1'b1, 0);
        send_frame(8'hFE, 48'h0000_0000_00FF, 1'b1, 1'b1, 0);
    endtask

    // Mostly well-formed frames with random content, plus noise bytes,
    // cut-off frames that run into a timeout below 300, and bursts of ticks.
    task automatic run_random_phase(input int budget);
        int stop_at;
        int roll;
        int n;
        logic [7:0]  cmd;
        logic [47:0] body;
        stop_at = useful_words + budget;
        while (useful_words < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 70) begin
                cmd  = ($urandom_range(1) != 0) ? cfg_query_reply : 8'($urandom);
                body = {16'($urandom), 32'($urandom)};
                if ($urandom_range(1) != 0)
                    body[7:0] = cfg_request;
                send_frame(cmd, body, $urandom_range(99) < 75, $urandom_range(99) < 85, 5);
            end else if (roll < 80) begin
                n = $urandom_range(5, 1);
                repeat (n) send_word(KIND_BYTE, 8'($urandom));
            end else if (roll < 90) begin
                send_word(KIND_BYTE, HEAD_BYTE);
                n = $urandom_range(8);
                repeat (n) send_word(KIND_BYTE, 8'($urandom));
                if (cfg_timeout < 300) begin
                    n = int'(cfg_timeout) + 1 - int'(tick_age);
                    if (n < 1)
                        n = 1;
                end else begin
                    n = $urandom_range(5, 1);
                end
                send_ticks(n);
            end else begin
                send_ticks($urandom_range(10, 1));
            end
        end
    endtask

    task automatic test_random_traffic();
        int phase;
        int roll;
        logic [15:0] timeout;
        logic [7:0]  request;
        logic [7:0]  query_req;
        logic [7:0]  query_reply;
        for (phase = 0; phase < 6; phase++) begin
            roll = $urandom_range(99);
            if (roll < 20)
                timeout = 16'($urandom_range(4, 1));
            else if (roll < 70)
                timeout = 16'($urandom_range(300, 20));
            else if (roll < 85)
                timeout = 16'hFFFF;
            else
                timeout = 16'($urandom);
            query_req   = 8'($urandom);
            request     = ($urandom_range(1) != 0) ? query_req : 8'($urandom);
            query_reply = ($urandom_range(1) != 0) ? 8'hC0 : 8'($urandom);
            load_settings(timeout, request, query_req, query_reply);
            run_random_phase(250);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        cfg_timeout     = TIMEOUT_RESET;
        cfg_request     = REQUEST_RESET;
        cfg_query_req   = QUERY_REQUEST_RESET;
        cfg_query_reply = QUERY_REPLY_RESET;
        rearm_hunt();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_hunt_and_clean_frame();
        test_frame_faults();
        test_timeout_edges();
        test_tick_saturation();
        test_request_matching();
        test_random_traffic();

        drain_replies();
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
